// File: rtl/dfr_pkg.sv
`default_nettype none
package dfr_pkg;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'b0001,
      PH_LEN   = 4'b0010,
      PH_BODY  = 4'b0100,
      PH_CHECK = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      ST_GOOD     = 2'd0,
      ST_SKIPPED  = 2'd1,
      ST_MISMATCH = 2'd2,
      ST_BAD_LEN  = 2'd3
   } status_type;

   localparam logic KIND_BODY   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0]  FIELD_LAST  = 3'd3;   // fourth char of a field
   localparam logic [15:0] MIN_LENGTH  = 16'd8;
   localparam logic [15:0] LEN_HDR     = 16'd4;
   localparam logic [7:0]  CHAR_X      = 8'h58;
   localparam logic [7:0]  START_RESET = 8'd35;

   localparam logic [1:0]  ADDR_START  = 2'd0;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] body_byte;
      logic [7:0] body_index;
      status_type frame_status;
   } rsp_type;

   // digit value in [3:0], bit 4 set for a non-hex character
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      d = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = {1'b0, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = {1'b0, 4'(c - 8'h57)};
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// File: rtl/dfr_csr.sv
`default_nettype none
module dfr_csr
   import dfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output logic      [7:0]  start_byte
);

   logic [7:0] start_ff;
   logic [7:0] start_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == ADDR_START);

   always_comb begin
      start_in = start_ff;
      if (wr_en) begin
         start_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
      end else begin
         start_ff <= start_in;
      end
   end

   assign csr_prdata = (csr_paddr == ADDR_START) ? {24'd0, start_ff} : 32'd0;
   assign start_byte = start_ff;

endmodule
`default_nettype wire

// File: rtl/dfr_core.sv
`default_nettype none
module dfr_core
   import dfr_pkg::*;
#(
   parameter int MAX_BODY = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] start_byte,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   output logic            in_ready,
   output logic            out_valid,
   input  wire logic       out_ready,
   output rsp_type         out_rsp
);

   localparam int CntW = $clog2(MAX_BODY + 1);
   localparam logic [15:0] BodyCap = 16'(MAX_BODY);

   phase_type       phase_ff, phase_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [15:0]     len_ff, len_in;
   logic [19:0]     sum_ff, sum_in;
   logic [15:0]     chk_ff, chk_in;
   logic            open_ff, open_in;
   logic            allx_ff, allx_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            advance;
   logic            emit;
   logic [4:0]      digit;
   logic [CntW-1:0] count_inc;
   logic [15:0]     len_hex;
   logic [15:0]     chk_hex;
   logic [15:0]     len_m4;
   logic [15:0]     body_len;
   logic [19:0]     sum_add;

   assign in_ready = !out_valid_ff || out_ready;
   assign advance  = in_valid && in_ready;
   assign digit    = hex_digit(in_byte);
   assign count_inc = count_ff + CntW'(1);
   assign sum_add  = sum_ff + 20'(in_byte);
   assign len_hex  = (open_ff && !digit[4]) ? {len_ff[11:0], digit[3:0]} : len_ff;
   assign chk_hex  = (open_ff && !digit[4]) ? {chk_ff[11:0], digit[3:0]} : chk_ff;
   assign len_m4   = len_ff - LEN_HDR;
   assign body_len = (len_m4 > BodyCap) ? BodyCap : len_m4;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      chk_in   = chk_ff;
      open_in  = open_ff;
      allx_in  = allx_ff;
      emit     = 1'b0;
      rsp_in.item_kind    = KIND_STATUS;
      rsp_in.body_byte    = 8'd0;
      rsp_in.body_index   = 8'd0;
      rsp_in.frame_status = ST_GOOD;
      case (phase_ff)
         PH_HUNT: begin
            if (in_byte == start_byte) begin
               phase_in = PH_LEN;
               count_in = '0;
               len_in   = 16'd0;
               sum_in   = 20'd0;
               chk_in   = 16'd0;
               open_in  = 1'b1;
               allx_in  = 1'b1;
            end
         end
         PH_LEN: begin
            sum_in   = sum_add;
            len_in   = len_hex;
            open_in  = open_ff && !digit[4];
            count_in = count_inc;
            if (count_ff == CntW'(FIELD_LAST)) begin
               count_in = '0;
               if (len_hex < MIN_LENGTH) begin
                  phase_in            = PH_HUNT;
                  emit                = 1'b1;
                  rsp_in.frame_status = ST_BAD_LEN;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            sum_in            = sum_add;
            emit              = 1'b1;
            rsp_in.item_kind  = KIND_BODY;
            rsp_in.body_byte  = in_byte;
            rsp_in.body_index = 8'(count_ff);
            count_in          = count_inc;
            if (16'(count_inc) >= body_len) begin
               phase_in = PH_CHECK;
               count_in = '0;
               chk_in   = 16'd0;
               open_in  = 1'b1;
               allx_in  = 1'b1;
            end
         end
         PH_CHECK: begin
            chk_in   = chk_hex;
            open_in  = open_ff && !digit[4];
            allx_in  = allx_ff && (in_byte == CHAR_X);
            count_in = count_inc;
            if (count_ff == CntW'(FIELD_LAST)) begin
               count_in = '0;
               phase_in = PH_HUNT;
               emit     = 1'b1;
               if (allx_in) begin
                  rsp_in.frame_status = ST_SKIPPED;
               end else if (sum_ff == {4'd0, chk_hex}) begin
                  rsp_in.frame_status = ST_GOOD;
               end else begin
                  rsp_in.frame_status = ST_MISMATCH;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = emit;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         len_ff       <= 16'd0;
         sum_ff       <= 20'd0;
         chk_ff       <= 16'd0;
         open_ff      <= 1'b1;
         allx_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            len_ff   <= len_in;
            sum_ff   <= sum_in;
            chk_ff   <= chk_in;
            open_ff  <= open_in;
            allx_ff  <= allx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;

`ifndef SYNTHESIS
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ff.item_kind == KIND_STATUS)
         |-> (rsp_ff.body_byte == 8'd0 && rsp_ff.body_index == 8'd0))
      else $error("status transfer carries body data");

   a_body_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ff.item_kind == KIND_BODY)
         |-> (rsp_ff.frame_status == ST_GOOD))
      else $error("body transfer carries a status");

   a_status_hunts: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && rsp_in.item_kind == KIND_STATUS) |=> (phase_ff == PH_HUNT))
      else $error("frame ended without return to hunt");

   a_field_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN || phase_ff == PH_CHECK) |-> (count_ff <= CntW'(FIELD_LAST)))
      else $error("field character count overrun");
`endif

endmodule
`default_nettype wire

// File: rtl/ascii_command_frame_deframer.sv
`default_nettype none
// Path: req transfer -> input register -> result register -> rsp transfer.
// Throughput: one byte per cycle while rsp is not stalled, with no dead
// cycles between frames.
// Reset (synchronous): deframer hunts for the start byte, counters and sums
// cleared, start byte register reads 35.
module ascii_command_frame_deframer
   import dfr_pkg::*;
#(
   parameter int MAX_BODY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // [7:0] body_byte, [15:8] body_index,
                                         // [17:16] frame_status, [23:18] zero
   output logic             rsp_tuser,   // item_kind
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic       req_valid_ff, req_valid_in;
   logic [7:0] req_byte_ff;
   logic       core_ready;
   logic       req_take;
   logic [7:0] start_byte;
   rsp_type    rsp;

   assign req_tready = !req_valid_ff || core_ready;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (core_ready) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_byte_ff <= req_tdata;
      end
   end

   dfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .start_byte  (start_byte)
   );

   dfr_core #(
      .MAX_BODY (MAX_BODY)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .start_byte (start_byte),
      .in_valid   (req_valid_ff),
      .in_byte    (req_byte_ff),
      .in_ready   (core_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rsp    (rsp)
   );

   assign rsp_tdata = {6'd0, rsp.frame_status, rsp.body_index, rsp.body_byte};
   assign rsp_tuser = rsp.item_kind;

endmodule
`default_nettype wire

// File: verif/deframer_checker.sv
module deframer_checker
   import dfr_pkg::*;
#(
   parameter int MAX_BODY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               mismatch_count,
   output int               items_owed
);

   localparam int FIELD_CHARS = 4;

   phase_type   phase;
   logic [7:0]  sync_byte;
   int          char_count;
   logic [15:0] frame_length;
   logic [15:0] check_value;
   logic [19:0] running_sum;
   bit          prefix_open;
   bit          all_x;
   rsp_type     frame_items[$];

   function automatic int hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
      return -1;
   endfunction

   // digits count only until the first non-hex character of the field
   task automatic take_digit(inout logic [15:0] acc, input logic [7:0] c);
      int d;
      d = hex_value(c);
      if (prefix_open) begin
         if (d < 0) begin
            prefix_open = 1'b0;
         end else begin
            acc = {acc[11:0], d[3:0]};
         end
      end
   endtask

   function automatic rsp_type status_item(input status_type st);
      rsp_type r;
      r = '0;
      r.item_kind = KIND_STATUS;
      r.frame_status = st;
      return r;
   endfunction

   task automatic deframe_byte(input logic [7:0] c);
      rsp_type r;
      int      body_len;
      case (phase)
         PH_HUNT: begin
            if (c == sync_byte) begin
               phase = PH_LEN;
               char_count = 0;
               frame_length = '0;
               running_sum = '0;
               check_value = '0;
               prefix_open = 1'b1;
               all_x = 1'b1;
            end
         end
         PH_LEN: begin
            running_sum += c;
            take_digit(frame_length, c);
            char_count++;
            if (char_count == FIELD_CHARS) begin
               char_count = 0;
               if (frame_length < MIN_LENGTH) begin
                  phase = PH_HUNT;
                  frame_items.push_back(status_item(ST_BAD_LEN));
               end else begin
                  phase = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            running_sum += c;
            r = '0;
            r.item_kind = KIND_BODY;
            r.body_byte = c;
            r.body_index = char_count[7:0];
            r.frame_status = ST_GOOD;
            frame_items.push_back(r);
            char_count++;
            body_len = int'(frame_length - LEN_HDR);
            if (body_len > MAX_BODY) body_len = MAX_BODY;
            if (char_count >= body_len) begin
               phase = PH_CHECK;
               char_count = 0;
               check_value = '0;
               prefix_open = 1'b1;
               all_x = 1'b1;
            end
         end
         default: begin
            take_digit(check_value, c);
            if (c != CHAR_X) all_x = 1'b0;
            char_count++;
            if (char_count == FIELD_CHARS) begin
               char_count = 0;
               phase = PH_HUNT;
               if (all_x) begin
                  frame_items.push_back(status_item(ST_SKIPPED));
               end else if (running_sum == {4'd0, check_value}) begin
                  frame_items.push_back(status_item(ST_GOOD));
               end else begin
                  frame_items.push_back(status_item(ST_MISMATCH));
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         phase = PH_HUNT;
         sync_byte = START_RESET;
         char_count = 0;
         frame_length = '0;
         running_sum = '0;
         check_value = '0;
         prefix_open = 1'b1;
         all_x = 1'b1;
         frame_items.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == ADDR_START) begin
            sync_byte = csr_pwdata[7:0];
         end
         if (req_tvalid && req_tready) deframe_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            seen.item_kind = rsp_tuser;
            seen.body_byte = rsp_tdata[7:0];
            seen.body_index = rsp_tdata[15:8];
            seen.frame_status = status_type'(rsp_tdata[17:16]);
            if (frame_items.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transfer, expected none,", $time);
               $display("%0t:   got kind %0d byte %02h index %0d status %0d",
                        $time, seen.item_kind, seen.body_byte, seen.body_index,
                        seen.frame_status);
            end else begin
               want = frame_items.pop_front();
               if (seen !== want || rsp_tdata[23:18] !== 6'd0) begin
                  mismatch_count++;
                  $display("%0t: mismatch, expected kind %0d byte %02h index %0d status %0d pad 00",
                           $time, want.item_kind, want.body_byte, want.body_index,
                           want.frame_status);
                  $display("%0t:           got kind %0d byte %02h index %0d status %0d pad %02h",
                           $time, seen.item_kind, seen.body_byte, seen.body_index,
                           seen.frame_status, rsp_tdata[23:18]);
               end
            end
         end
      end
      items_owed = frame_items.size();
   end

endmodule

// File: verif/tb.sv
module tb;
   import dfr_pkg::*;

   localparam int BODY_CAP  = 256;
   localparam int SEGMENTS  = 6;
   localparam int SEG_BYTES = 60;

   typedef enum int {CHK_GOOD, CHK_SKIP, CHK_BAD, CHK_PREFIX, CHK_NOISE} check_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = 2'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatches;
   int          owed;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          bytes_sent = 0;
   int          frame_sum = 0;
   logic [7:0]  sync_byte = START_RESET;

   ascii_command_frame_deframer #(.MAX_BODY(BODY_CAP)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   deframer_checker #(.MAX_BODY(BODY_CAP)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .mismatch_count(mismatches), .items_owed(owed)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // valid stays high after a transfer; the next byte or an idle cycle decides
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) begin
         frame_sum += w[8*i +: 8];
         send_byte(w[8*i +: 8]);
      end
   endtask

   function automatic logic [31:0] hex4(input logic [15:0] v);
      logic [31:0] w;
      logic [3:0]  n;
      for (int i = 0; i < 4; i++) begin
         n = v[4*i +: 4];
         if (n < 4'd10) begin
            w[8*i +: 8] = 8'h30 + n;
         end else if ($urandom_range(1)) begin
            w[8*i +: 8] = 8'h41 + (n - 4'd10);
         end else begin
            w[8*i +: 8] = 8'h61 + (n - 4'd10);
         end
      end
      return w;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(5))
         0: return CHAR_X;
         1: return sync_byte;
         2: return 8'(8'h20 + $urandom_range(94));
         3: return $urandom_range(1) ? 8'h00 : 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic check_kind_type pick_check();
      int r;
      r = $urandom_range(99);
      if (r < 55) return CHK_GOOD;
      if (r < 70) return CHK_SKIP;
      if (r < 82) return CHK_BAD;
      if (r < 90) return CHK_PREFIX;
      return CHK_NOISE;
   endfunction

   // fill < 0 picks each body byte at random
   task automatic send_head(input logic [31:0] len_chars, input int body_n, input int fill);
      logic [7:0] b;
      frame_sum = 0;
      send_byte(sync_byte);
      send_word(len_chars);
      for (int i = 0; i < body_n; i++) begin
         b = (fill < 0) ? pick_byte() : fill[7:0];
         frame_sum += b;
         send_byte(b);
      end
   endtask

   task automatic send_check(input check_kind_type kind);
      logic [31:0] w;
      logic [31:0] t;
      logic [15:0] s;
      s = frame_sum[15:0];
      case (kind)
         CHK_GOOD: w = hex4(s);
         CHK_SKIP: w = "XXXX";
         CHK_BAD: w = hex4(s ^ 16'($urandom_range(1, 65535)));
         CHK_PREFIX: begin
            t = hex4(s);
            w = {t[23:0], "q"};
         end
         default: w = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
      endcase
      send_word(w);
   endtask

   task automatic send_frame(input logic [15:0] len_val, input check_kind_type kind);
      int n;
      n = 0;
      if (len_val >= MIN_LENGTH) n = (len_val - 4 > BODY_CAP) ? BODY_CAP : len_val - 4;
      send_head(hex4(len_val), n, -1);
      if (len_val >= MIN_LENGTH) send_check(kind);
   endtask

   // wait out all results, then the pipeline, before touching the register
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (owed != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      int         target;
      int         r;
      logic [7:0] cfg;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_frame(16'h0008, CHK_GOOD);
      send_frame(16'h000C, CHK_SKIP);
      send_frame(16'h0010, CHK_BAD);
      send_frame(16'h0014, CHK_PREFIX);
      send_frame(16'h0009, CHK_NOISE);
      send_head("0007", 0, -1);
      send_head("0000", 0, -1);
      send_head("zz#9", 0, -1);
      send_head("7x12", 0, -1);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CHAR_X);
      send_head("9#F0", 5, START_RESET);
      send_check(CHK_GOOD);
      send_head("00a.", 6, CHAR_X);
      send_check(CHK_GOOD);
      send_head("001f", 27, 8'h00);
      send_check(CHK_GOOD);
      send_head("000D", 9, 8'hFF);
      send_word("XXX0");
      send_head("0008", 4, -1);
      send_word("X0XX");
      send_head("0104", 256, -1);
      send_check(CHK_GOOD);
      // sum past 16 bits: never matches, unless skipped
      send_head("FFFF", 256, 8'hFF);
      send_check(CHK_GOOD);
      send_head("FFFF", 256, 8'hFF);
      send_check(CHK_SKIP);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         case (seg)
            0: cfg = 8'h00;
            1: cfg = 8'hFF;
            3: cfg = START_RESET;
            5: cfg = CHAR_X;
            default: cfg = $urandom_range(255);
         endcase
         csr_write(ADDR_START, {24'd0, cfg});
         sync_byte = cfg;
         case (seg % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 49; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 49; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         target = bytes_sent + SEG_BYTES;
         while (bytes_sent < target) begin
            r = $urandom_range(99);
            if (r < 4) begin
               repeat ($urandom_range(1, 6)) send_byte(pick_byte());
            end else if (r < 7) begin
               // frame cut short: the next bytes land in its body
               send_head(hex4(16'($urandom_range(8, 40))), $urandom_range(0, 3), -1);
            end else if (r < 17) begin
               send_frame(16'($urandom_range(0, 7)), CHK_GOOD);
            end else if (r < 20) begin
               send_frame(16'($urandom_range(260, 65535)), pick_check());
            end else begin
               send_frame(16'($urandom_range(8, 40)), pick_check());
            end
         end
      end

      settle();
      if (mismatches == 0 && owed == 0) begin
         $display("ascii_command_frame_deframer test passed");
      end else begin
         $display("ascii_command_frame_deframer test failed");
      end
      $finish;
   end

   initial begin
      #3200000;
      $display("ascii_command_frame_deframer test failed");
      $finish;
   end

endmodule
